[design/gray_adjust_nibble_pack_assert.svh]
// Assertion macros shared by the gray adjust nibble pack design.
`ifndef GRAY_ADJUST_NIBBLE_PACK_ASSERT_SVH
`define GRAY_ADJUST_NIBBLE_PACK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GAN_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GAN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/gan_pkg.sv]
// Types and constants shared by the gray adjust nibble pack design.
package gan_pkg;

    localparam int GAMMA_DEPTH_DEF = 256;
    localparam int COORD_W         = 12;
    localparam int PIXEL_W         = 16;
    localparam int GRAY_W          = 8;
    localparam int ADDR_W          = 23;
    localparam int NIBBLE_W        = 4;
    localparam int REG_IDX_W       = 2;
    localparam int REG_DATA_W      = 13;
    localparam int CONTRAST_W      = 9;
    localparam int BRIGHT_W        = 8;
    localparam int GAMMA_W         = 9;
    localparam int WIDTH_W         = 13;
    localparam int DIV_IN_W        = 18;
    localparam int DIV_OUT_W       = 11;

    localparam logic [CONTRAST_W-1:0] CONTRAST_RESET = 9'd100;
    localparam logic [BRIGHT_W-1:0]   BRIGHT_RESET   = 8'd0;
    localparam logic [GAMMA_W-1:0]    GAMMA_RESET    = 9'd100;
    localparam logic [GAMMA_W-1:0]    GAMMA_BYPASS   = 9'd100;
    localparam logic [WIDTH_W-1:0]    WIDTH_RESET    = 13'd960;

    localparam logic [18:0] RECIP_100   = 19'd335545;
    localparam int          RECIP_SHIFT = 25;
    localparam int          MID_GRAY    = 128;
    localparam int          FULL_SCALE  = 255;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CONTRAST   = 2'd0,
        REG_BRIGHTNESS = 2'd1,
        REG_GAMMA      = 2'd2,
        REG_WIDTH      = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_TABLE = 1'b1
    } t_op;

endpackage

[design/gan_if.sv]
// Stream and configuration interfaces of the gray adjust nibble pack design.
interface gan_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [gan_pkg::PIXEL_W-1:0] pixel;
    logic [gan_pkg::COORD_W-1:0] block_x;
    logic [gan_pkg::COORD_W-1:0] block_y;
    logic [gan_pkg::COORD_W-1:0] column;
    logic [gan_pkg::COORD_W-1:0] line;
    logic [gan_pkg::GRAY_W-1:0]  table_index;
    logic [gan_pkg::GRAY_W-1:0]  table_value;

    modport source (output valid, op, pixel, block_x, block_y, column, line,
                    table_index, table_value, input ready);
    modport sink (input valid, op, pixel, block_x, block_y, column, line,
                  table_index, table_value, output ready);
endinterface

interface gan_out_if;
    logic                         valid;
    logic                         ready;
    logic [gan_pkg::ADDR_W-1:0]   byte_address;
    logic [gan_pkg::NIBBLE_W-1:0] nibble_value;
    logic                         high_nibble;

    modport source (output valid, byte_address, nibble_value, high_nibble, input ready);
    modport sink (input valid, byte_address, nibble_value, high_nibble, output ready);
endinterface

interface gan_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gan_pkg::REG_IDX_W-1:0]  index;
    logic [gan_pkg::REG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/gray_adjust_nibble_pack.sv]
// Gray level adjustment and 4-bit framebuffer nibble write generator.
//
// The block takes one transfer per clock while the output is not stalled and
// presents its nibble write through a four-stage pipeline: contrast multiply
// and row address multiply, divide by 100, brightness add with clamp, then
// gamma table read into the output register. Ready is chained stage by
// stage, so only a stalled output slows the input, and empty stages keep
// taking input while a result waits. Gamma table writes travel the same
// pipeline and write the table in the read stage, which keeps them in order
// with pixel reads; they produce no output transfer. The gamma table holds no
// defined contents until software loads it.
`include "gray_adjust_nibble_pack_assert.svh"

module gray_adjust_nibble_pack #(
    parameter int GAMMA_DEPTH = gan_pkg::GAMMA_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gan_in_if.sink    i_in,
    gan_out_if.source o_out,
    gan_cfg_if.sink   i_cfg
);
    import gan_pkg::*;

    localparam int IDX_W = $clog2(GAMMA_DEPTH);

    logic [CONTRAST_W-1:0]       r_contrast;
    logic signed [BRIGHT_W-1:0]  r_brightness;
    logic [GAMMA_W-1:0]          r_gamma;
    logic [WIDTH_W-1:0]          r_width;

    logic a1, a2, a3, a4;

    logic                        r_v1, r_op1;
    logic signed [DIV_IN_W-1:0]  r_prod1;
    logic [24:0]                 r_rowp1;
    logic [COORD_W:0]            r_col1;
    logic [GRAY_W-1:0]           r_tidx1, r_tval1;

    logic                        r_v2, r_op2, r_hi2;
    logic [ADDR_W-1:0]           r_addr2;
    logic [GRAY_W-1:0]           r_tidx2, r_tval2;
    logic signed [DIV_OUT_W-1:0] w_quo2, w_bt;

    logic                        r_v3, r_op3, r_hi3;
    logic [ADDR_W-1:0]           r_addr3;
    logic [GRAY_W-1:0]           r_tidx3, r_tval3, r_val3;

    logic                        r_v4, r_hi4, r_gam4;
    logic [ADDR_W-1:0]           r_addr4;
    logic [GRAY_W-1:0]           r_val4, r_rd;

    logic [GRAY_W-1:0]           r_mem [GAMMA_DEPTH];

    logic signed [18:0]          w_d, w_c, w_prod;
    logic [24:0]                 w_row, w_half, w_rowp;
    logic signed [DIV_IN_W-1:0]  w_bnum;
    logic signed [12:0]          w_sum;
    logic [GRAY_W-1:0]           w_clamp;
    logic                        w_tbl4, w_pix4;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contrast   <= CONTRAST_RESET;
            r_brightness <= BRIGHT_RESET;
            r_gamma      <= GAMMA_RESET;
            r_width      <= WIDTH_RESET;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_CONTRAST:   r_contrast   <= i_cfg.data[CONTRAST_W-1:0];
                REG_BRIGHTNESS: r_brightness <= i_cfg.data[BRIGHT_W-1:0];
                REG_GAMMA:      r_gamma      <= i_cfg.data[GAMMA_W-1:0];
                REG_WIDTH:      r_width      <= i_cfg.data[WIDTH_W-1:0];
                default:        r_width      <= r_width;
            endcase
        end
    end

    assign a4 = !r_v4 || o_out.ready;
    assign a3 = !r_v3 || a4;
    assign a2 = !r_v2 || a3;
    assign a1 = !r_v1 || a2;
    assign i_in.ready = a1;

    always_comb begin
        w_d    = 19'(signed'({1'b0, i_in.pixel[GRAY_W-1:0]})) - 19'sd128;
        w_c    = 19'(signed'({1'b0, r_contrast}));
        w_prod = w_d * w_c;
        w_row  = 25'(i_in.block_y) + 25'(i_in.line);
        w_half = 25'(r_width[WIDTH_W-1:1]);
        w_rowp = w_row * w_half;
        w_bnum = DIV_IN_W'(r_brightness) * 18'sd255;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (a1) begin
            r_v1 <= i_in.valid;
        end
        if (a1) begin
            r_op1   <= i_in.op;
            r_prod1 <= w_prod[DIV_IN_W-1:0];
            r_rowp1 <= w_rowp;
            r_col1  <= (COORD_W+1)'(i_in.block_x) + (COORD_W+1)'(i_in.column);
            r_tidx1 <= i_in.table_index;
            r_tval1 <= i_in.table_value;
        end
    end

    gan_div100 u_div_contrast (
        .i_clk (i_clk),
        .i_en  (a2),
        .i_num (r_prod1),
        .o_quo (w_quo2)
    );

    gan_div100 u_div_bright (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_num (w_bnum),
        .o_quo (w_bt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (a2) begin
            r_v2 <= r_v1;
        end
        if (a2) begin
            r_op2   <= r_op1;
            r_addr2 <= r_rowp1[ADDR_W-1:0] + ADDR_W'(r_col1[COORD_W:1]);
            r_hi2   <= r_col1[0];
            r_tidx2 <= r_tidx1;
            r_tval2 <= r_tval1;
        end
    end

    always_comb begin
        w_sum = 13'sd128 + {{2{w_quo2[DIV_OUT_W-1]}}, w_quo2}
              + {{2{w_bt[DIV_OUT_W-1]}}, w_bt};
        if (w_sum < 13'sd0) begin
            w_clamp = '0;
        end else if (w_sum > 13'sd255) begin
            w_clamp = 8'(FULL_SCALE);
        end else begin
            w_clamp = w_sum[GRAY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (a3) begin
            r_v3 <= r_v2;
        end
        if (a3) begin
            r_op3   <= r_op2;
            r_addr3 <= r_addr2;
            r_hi3   <= r_hi2;
            r_tidx3 <= r_tidx2;
            r_tval3 <= r_tval2;
            r_val3  <= w_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a4) begin
            if (r_v3 && (r_op3 == OP_TABLE)) begin
                r_mem[r_tidx3[IDX_W-1:0]] <= r_tval3;
            end
            r_rd <= r_mem[r_val3[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (a4) begin
            r_v4 <= r_v3 && (r_op3 == OP_PIXEL);
        end
        if (a4) begin
            r_addr4 <= r_addr3;
            r_hi4   <= r_hi3;
            r_val4  <= r_val3;
            r_gam4  <= (r_gamma != GAMMA_BYPASS);
        end
    end

    assign o_out.valid        = r_v4;
    assign o_out.byte_address = r_addr4;
    assign o_out.high_nibble  = r_hi4;
    assign o_out.nibble_value = r_gam4 ? r_rd[GRAY_W-1:NIBBLE_W] : r_val4[GRAY_W-1:NIBBLE_W];

    assign w_tbl4 = r_v3 && (r_op3 == OP_TABLE) && a4;
    assign w_pix4 = r_v3 && (r_op3 == OP_PIXEL) && a4;

    `GAN_ASSERT_IMPLY(a_idle_ready, i_clk, i_rst_n, !o_out.valid, i_in.ready, "input stalled")
    `GAN_ASSERT_NEXT(a_table_silent, i_clk, i_rst_n, w_tbl4, !o_out.valid, "stray result")
    `GAN_ASSERT_NEXT(a_pixel_out, i_clk, i_rst_n, w_pix4, o_out.valid, "pixel result lost")

endmodule

[design/gan_div100.sv]
// Registered signed divide by 100, truncating toward zero, by reciprocal multiply.
module gan_div100 (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [gan_pkg::DIV_IN_W-1:0] i_num,
    output logic signed [gan_pkg::DIV_OUT_W-1:0] o_quo
);
    import gan_pkg::*;

    logic                        w_neg;
    logic [DIV_IN_W-1:0]         w_mag;
    logic [35:0]                 w_prod;
    logic [DIV_OUT_W-1:0]        w_q;
    logic signed [DIV_OUT_W-1:0] r_quo;

    always_comb begin
        w_neg  = i_num[DIV_IN_W-1];
        w_mag  = w_neg ? (~i_num + 1'b1) : i_num;
        w_prod = 36'(w_mag[DIV_IN_W-2:0]) * 36'(RECIP_100);
        w_q    = w_prod[RECIP_SHIFT+DIV_OUT_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= w_neg ? (~w_q + 1'b1) : w_q;
        end
    end

    assign o_quo = r_quo;

endmodule
